FILE: hdl/multiturn_angle_velocity_tracker_assert.svh
// Assertion macros for the multi-turn angle and velocity tracker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_ASSERT_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_ASSERT_SVH

// same-cycle implication
`define AVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/avt_pkg.sv
// Shared widths, register indexes, reset values and types of the tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

  localparam int COUNT_BITS = 12;
  localparam int TIMER_BITS = 24;
  localparam int TURN_BITS  = 20;
  localparam int POS_W      = 32;
  localparam int TPS_W      = 27;
  localparam int CFG_W      = 32;
  localparam int REG_IDX_W  = 2;

  localparam int MUL_DIGITS = (TPS_W + 1) / 2;
  localparam int MPL_W      = 2 * MUL_DIGITS;
  localparam int ACC_W      = POS_W + 2;
  localparam int NUM_W      = ACC_W + MPL_W;
  localparam int DIV_DIGITS = NUM_W / 2;
  localparam int QUO_W      = POS_W + 2;
  localparam int DVS3_W     = TIMER_BITS + 2;
  localparam int MCNT_W     = $clog2(MUL_DIGITS);
  localparam int DCNT_W     = $clog2(DIV_DIGITS);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [TURN_BITS-1:0]  turn_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [TPS_W-1:0]      tps_t;
  typedef logic [QUO_W-1:0]      quo_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  localparam reg_idx_t REG_WRAP_THR = REG_IDX_W'(0);
  localparam reg_idx_t REG_TPS      = REG_IDX_W'(1);
  localparam reg_idx_t REG_MAX_IV   = REG_IDX_W'(2);
  localparam reg_idx_t REG_FB_IV    = REG_IDX_W'(3);

  localparam count_t RST_WRAP_THR = COUNT_BITS'(3276);
  localparam tps_t   RST_TPS      = TPS_W'(9000000);
  localparam timer_t RST_MAX_IV   = TIMER_BITS'(4500000);
  localparam timer_t RST_FB_IV    = TIMER_BITS'(9000);

  localparam quo_t QUO_NEG_LIM = QUO_W'(1) << (POS_W - 1);
  localparam quo_t QUO_POS_LIM = QUO_NEG_LIM - QUO_W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/multiturn_angle_velocity_tracker.sv
// Top level of the multi-turn angle and velocity tracker: registers, sequencer,
// saturation and output register. Depends on avt_pkg, avt_track, avt_mul, avt_div.
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid/in_ready    in_raw_count, in_timer_value
//   out_     source     out_valid/out_ready  out_position, out_velocity
//   cfg_     sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted word passes through tracking, 14 radix-4 multiply steps,
// 31 radix-4 divide steps and the output load. The next word is taken once
// the result is loaded, while that result may still wait on out_ready.
// Reset is synchronous, no clear pass.
`timescale 1ns / 1ps
`default_nettype none
`include "multiturn_angle_velocity_tracker_assert.svh"

module multiturn_angle_velocity_tracker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  avt_pkg::count_t          in_raw_count,
  input  avt_pkg::timer_t          in_timer_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       out_position,
  output logic signed [31:0]       out_velocity,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  avt_pkg::reg_idx_t        cfg_index,
  input  logic [avt_pkg::CFG_W-1:0] cfg_data
);
  import avt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRK  = 3'd1;
  localparam logic [2:0] S_MGO  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  count_t thr_r;
  tps_t   tps_r;
  timer_t max_r;
  timer_t fb_r;

  logic   out_valid_r;
  pos_t   pos_out_r;
  pos_t   vel_out_r;

  logic   accept;
  logic   load_out;
  logic   mul_start;
  logic   div_start;

  pos_t   trk_pos;
  pos_t   trk_mag;
  logic   trk_neg;
  timer_t trk_iv;

  stat_t  mul_st;
  stat_t  div_st;
  logic [NUM_W-1:0] product;
  quo_t   quo;
  logic   quo_ovf;
  logic   big;
  quo_t   qs;
  pos_t   vel_nxt;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mul_start = (state_r == S_MGO);
  assign div_start = (state_r == S_MUL) && mul_st.done;
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  avt_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .step      (state_r == S_TRK),
    .raw       (in_raw_count),
    .now       (in_timer_value),
    .thr       (thr_r),
    .max_ticks (max_r),
    .fb_ticks  (fb_r),
    .pos       (trk_pos),
    .mag       (trk_mag),
    .neg       (trk_neg),
    .interval  (trk_iv)
  );

  avt_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (trk_mag),
    .mplr    (tps_r),
    .stat    (mul_st),
    .product (product)
  );

  avt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (trk_iv),
    .stat     (div_st),
    .quotient (quo),
    .ovf      (quo_ovf)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_TRK;
      S_TRK:  state_nxt = S_MGO;
      S_MGO:  state_nxt = S_MUL;
      S_MUL:  if (mul_st.done) state_nxt = S_DIV;
      S_DIV:  if (div_st.done) state_nxt = S_FIN;
      S_FIN:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (trk_neg) begin
      big     = quo_ovf || (quo > QUO_NEG_LIM);
      qs      = big ? QUO_NEG_LIM : quo;
      vel_nxt = POS_W'(QUO_W'(0) - qs);
    end else begin
      big     = quo_ovf || (quo > QUO_POS_LIM);
      qs      = big ? QUO_POS_LIM : quo;
      vel_nxt = POS_W'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= RST_WRAP_THR;
      tps_r       <= RST_TPS;
      max_r       <= RST_MAX_IV;
      fb_r        <= RST_FB_IV;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WRAP_THR: thr_r <= cfg_data[COUNT_BITS-1:0];
          REG_TPS:      tps_r <= cfg_data[TPS_W-1:0];
          REG_MAX_IV:   max_r <= cfg_data[TIMER_BITS-1:0];
          REG_FB_IV:    fb_r  <= cfg_data[TIMER_BITS-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_out_r <= trk_pos;
      vel_out_r <= vel_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = $signed(pos_out_r);
  assign out_velocity = $signed(vel_out_r);

  `AVT_ASSERT_NEXT(a_accept_tracks, accept, state_r == S_TRK, "accepted word did not start tracking")
  `AVT_ASSERT_NEXT(a_fin_holds, (state_r == S_FIN) && out_valid_r && !out_ready, (state_r == S_FIN) && out_valid_r, "result lost while output register full")
  `AVT_ASSERT_SAME(a_units_excl, mul_st.busy, !div_st.busy, "multiplier and divider busy together")
  `AVT_ASSERT_SAME(a_mul_done_state, mul_st.done, state_r == S_MUL, "multiplier finished outside its step")

endmodule

`default_nettype wire

FILE: hdl/avt_track.sv
// Turn tracking, multi-turn position, position change and interval selection.
// Depends on avt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avt_track (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            step,
  input  avt_pkg::count_t raw,
  input  avt_pkg::timer_t now,
  input  avt_pkg::count_t thr,
  input  avt_pkg::timer_t max_ticks,
  input  avt_pkg::timer_t fb_ticks,
  output avt_pkg::pos_t   pos,
  output avt_pkg::pos_t   mag,
  output logic            neg,
  output avt_pkg::timer_t interval
);
  import avt_pkg::*;

  count_t prev_raw_r;
  turn_t  turn_r;
  timer_t prev_timer_r;
  timer_t elapsed_r;
  pos_t   pos_r;
  pos_t   mag_r;
  logic   neg_r;
  timer_t interval_r;

  logic   up;
  count_t jump;
  turn_t  turn_nxt;
  timer_t elapsed_nxt;
  pos_t   pos_nxt;
  pos_t   d_fwd;
  pos_t   d_rev;
  timer_t iv_sel;
  timer_t interval_nxt;

  always_comb begin
    up   = raw > prev_raw_r;
    jump = up ? raw - prev_raw_r : prev_raw_r - raw;
    turn_nxt = turn_r;
    if (jump > thr) begin
      turn_nxt = up ? turn_r - TURN_BITS'(1) : turn_r + TURN_BITS'(1);
    end
    elapsed_nxt = (now < prev_timer_r) ? prev_timer_r - now : prev_timer_r + ~now;
  end

  always_comb begin
    pos_nxt = (POS_W'($signed(turn_r)) << COUNT_BITS) | POS_W'(prev_raw_r);
    d_fwd   = pos_nxt - pos_r;
    d_rev   = pos_r - pos_nxt;
    iv_sel  = (elapsed_r == '0 || elapsed_r > max_ticks) ? fb_ticks : elapsed_r;
    interval_nxt = (iv_sel == '0) ? TIMER_BITS'(1) : iv_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r   <= '0;
      turn_r       <= '0;
      prev_timer_r <= '0;
      pos_r        <= '0;
    end else begin
      if (load) begin
        prev_raw_r   <= raw;
        turn_r       <= turn_nxt;
        prev_timer_r <= now;
      end
      if (step) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      elapsed_r <= elapsed_nxt;
    end
    if (step) begin
      neg_r      <= d_fwd[POS_W-1];
      mag_r      <= d_fwd[POS_W-1] ? d_rev : d_fwd;
      interval_r <= interval_nxt;
    end
  end

  assign pos      = pos_r;
  assign mag      = mag_r;
  assign neg      = neg_r;
  assign interval = interval_r;

endmodule

`default_nettype wire

FILE: hdl/avt_mul.sv
// Radix-4 digit-serial multiplier: position change times tick rate.
// Depends on avt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avt_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  avt_pkg::pos_t             mcand,
  input  avt_pkg::tps_t             mplr,
  output avt_pkg::stat_t            stat,
  output logic [avt_pkg::NUM_W-1:0] product
);
  import avt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [MCNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]  hi_r;
  logic [MPL_W-1:0]  lo_r;
  logic [MPL_W-1:0]  mpl_r;
  logic [ACC_W-1:0]  m1_r;
  logic [ACC_W-1:0]  m3_r;

  logic [ACC_W-1:0]  md;
  logic [ACC_W:0]    sum;

  always_comb begin
    unique case (mpl_r[1:0])
      2'd0:    md = '0;
      2'd1:    md = m1_r;
      2'd2:    md = m1_r << 1;
      default: md = m3_r;
    endcase
    sum = {1'b0, hi_r} + {1'b0, md};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + MCNT_W'(1);
        if (cnt_r == MCNT_W'(MUL_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r  <= '0;
      lo_r  <= '0;
      mpl_r <= MPL_W'(mplr);
      m1_r  <= ACC_W'(mcand);
      m3_r  <= ACC_W'(mcand) + (ACC_W'(mcand) << 1);
    end else if (busy_r) begin
      hi_r  <= {1'b0, sum[ACC_W:2]};
      lo_r  <= {sum[1:0], lo_r[MPL_W-1:2]};
      mpl_r <= mpl_r >> 2;
    end
  end

  assign stat    = '{busy: busy_r, done: done_r};
  assign product = {hi_r, lo_r};

endmodule

`default_nettype wire

FILE: hdl/avt_div.sv
// Radix-4 digit-serial restoring divider with sticky quotient overflow.
// Depends on avt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [avt_pkg::NUM_W-1:0] dividend,
  input  avt_pkg::timer_t           divisor,
  output avt_pkg::stat_t            stat,
  output avt_pkg::quo_t             quotient,
  output logic                      ovf
);
  import avt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]  num_r;
  timer_t            rem_r;
  timer_t            d1_r;
  logic [DVS3_W-1:0] d3_r;
  quo_t              q_r;
  logic              ovf_r;

  logic [DVS3_W-1:0] t;
  logic [DVS3_W:0]   s1;
  logic [DVS3_W:0]   s2;
  logic [DVS3_W:0]   s3;
  logic [1:0]        qd;
  timer_t            rem_nxt;

  always_comb begin
    t  = {rem_r, num_r[NUM_W-1 -: 2]};
    s1 = {1'b0, t} - {3'b000, d1_r};
    s2 = {1'b0, t} - {2'b00, d1_r, 1'b0};
    s3 = {1'b0, t} - {1'b0, d3_r};
    priority if (!s3[DVS3_W]) begin
      qd      = 2'd3;
      rem_nxt = s3[TIMER_BITS-1:0];
    end else if (!s2[DVS3_W]) begin
      qd      = 2'd2;
      rem_nxt = s2[TIMER_BITS-1:0];
    end else if (!s1[DVS3_W]) begin
      qd      = 2'd1;
      rem_nxt = s1[TIMER_BITS-1:0];
    end else begin
      qd      = 2'd0;
      rem_nxt = t[TIMER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      d1_r  <= divisor;
      d3_r  <= DVS3_W'(divisor) + (DVS3_W'(divisor) << 1);
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_r << 2;
      rem_r <= rem_nxt;
      q_r   <= {q_r[QUO_W-3:0], qd};
      ovf_r <= ovf_r | (|q_r[QUO_W-1 -: 2]);
    end
  end

  assign stat     = '{busy: busy_r, done: done_r};
  assign quotient = q_r;
  assign ovf      = ovf_r;

endmodule

`default_nettype wire
